// File: src/rotated_two_plane_pixel_plotter_assert.svh
// Assertion macros used by the plotter control module.
// Each macro expects clk and arst_n to exist in the module that uses it.
`ifndef ROTATED_TWO_PLANE_PIXEL_PLOTTER_ASSERT_SVH
`define ROTATED_TWO_PLANE_PIXEL_PLOTTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RTPP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RTPP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/rtpp_pkg.sv
package rtpp_pkg;

	localparam int COORD_W   = 9;
	localparam int DIM_W     = 10;
	localparam int CMD_W     = 2;
	localparam int COLOUR_W  = 2;
	localparam int IDX_W     = 13;
	localparam int BYTE_DW   = 8;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DW    = 2;

	localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

	localparam logic [COLOUR_W-1:0] COL_BLACK = 2'd0;
	localparam logic [COLOUR_W-1:0] COL_WHITE = 2'd1;
	localparam logic [COLOUR_W-1:0] COL_RED   = 2'd2;

	localparam logic [1:0] ROT_0   = 2'd0;
	localparam logic [1:0] ROT_90  = 2'd1;
	localparam logic [1:0] ROT_180 = 2'd2;
	localparam logic [1:0] ROT_270 = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_ROTATION = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SWAP     = 1'd1;

	localparam logic [BYTE_DW-1:0] BYTE_ONES  = 8'hFF;
	localparam logic [BYTE_DW-1:0] BYTE_ZEROS = 8'h00;
	localparam logic [BYTE_DW-1:0] MASK_MSB   = 8'h80;

	typedef struct packed {
		logic load;
		logic map_en;
		logic mul_en;
		logic addr_en;
		logic rd_en;
		logic fill_en;
		logic fill_zero;
		logic commit;
	} rtpp_cmd_t;

	typedef struct packed {
		logic fill_last;
	} rtpp_stat_t;

endpackage

// File: src/rtpp_if.sv
interface rtpp_in_if import rtpp_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    cmd;
	logic [COORD_W-1:0]  pixel_x;
	logic [COORD_W-1:0]  pixel_y;
	logic [COLOUR_W-1:0] colour;
	logic [IDX_W-1:0]    byte_index;

	modport source (output valid, cmd, pixel_x, pixel_y, colour, byte_index, input ready);
	modport sink (input valid, cmd, pixel_x, pixel_y, colour, byte_index, output ready);
endinterface

interface rtpp_out_if import rtpp_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               accepted;
	logic [BYTE_DW-1:0] black_byte;
	logic [BYTE_DW-1:0] red_byte;

	modport source (output valid, accepted, black_byte, red_byte, input ready);
	modport sink (input valid, accepted, black_byte, red_byte, output ready);
endinterface

// File: src/rtpp_datapath.sv
module rtpp_datapath import rtpp_pkg::*; #(
	parameter int PANEL_WIDTH  = 128,
	parameter int PANEL_HEIGHT = 296
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rtpp_cmd_t            ctl,
	output rtpp_stat_t           stat,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_DW-1:0]    wr_data,
	input  logic [CMD_W-1:0]     in_cmd,
	input  logic [COORD_W-1:0]   in_x,
	input  logic [COORD_W-1:0]   in_y,
	input  logic [COLOUR_W-1:0]  in_colour,
	input  logic [IDX_W-1:0]     in_index,
	output logic                 res_accepted,
	output logic [BYTE_DW-1:0]   res_black,
	output logic [BYTE_DW-1:0]   res_red
);

	localparam int PLANE_BYTES = (PANEL_WIDTH * PANEL_HEIGHT) / 8;
	localparam int AW          = $clog2(PLANE_BYTES);
	localparam int PROD_W      = COORD_W + DIM_W;
	localparam int SUM_W       = PROD_W + 1;
	localparam int BADDR_W     = SUM_W - 3;

	localparam logic [DIM_W-1:0]   WIDTH_D  = DIM_W'(PANEL_WIDTH);
	localparam logic [DIM_W-1:0]   HEIGHT_D = DIM_W'(PANEL_HEIGHT);
	localparam logic [BADDR_W-1:0] PB_D     = BADDR_W'(PLANE_BYTES);
	localparam logic [AW-1:0]      LAST_D   = AW'(PLANE_BYTES - 1);

	logic [1:0]            rot_q;
	logic                  swap_q;
	logic [CMD_W-1:0]      cmd_q;
	logic [COORD_W-1:0]    ox_q, oy_q;
	logic [COLOUR_W-1:0]   colour_q;
	logic [IDX_W-1:0]      idx_q;
	logic [COORD_W-1:0]    x_q, y_q;
	logic                  ok_q;
	logic [PROD_W-1:0]     prod_q;
	logic [AW-1:0]         addr_q;
	logic                  hit_q;
	logic [AW-1:0]         fill_cnt_q;
	logic [BYTE_DW-1:0]    rd_black_q, rd_red_q;

	logic [BYTE_DW-1:0]    black_mem [PLANE_BYTES];
	logic [BYTE_DW-1:0]    red_mem [PLANE_BYTES];

	logic [DIM_W-1:0]      w_d, h_d;
	logic [DIM_W-1:0]      ox_e, oy_e;
	logic [DIM_W-1:0]      map_x, map_y;
	logic                  map_ok;
	logic [SUM_W-1:0]      sum;
	logic [BADDR_W-1:0]    draw_byte, read_byte;
	logic [BYTE_DW-1:0]    mask;
	logic                  set_black, set_red;
	logic [BYTE_DW-1:0]    new_black, new_red;
	logic [BYTE_DW-1:0]    fill_black, fill_red;
	logic                  we;
	logic [AW-1:0]         waddr;
	logic [BYTE_DW-1:0]    wdata_black, wdata_red;
	logic                  draw_commit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q  <= ROT_0;
			swap_q <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				REG_ROTATION: rot_q  <= wr_data[1:0];
				REG_SWAP:     swap_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q    <= in_cmd;
			ox_q     <= in_x;
			oy_q     <= in_y;
			colour_q <= in_colour;
			idx_q    <= in_index;
		end
	end

	// Odd rotations exchange the panel's width and height.
	assign w_d  = rot_q[0] ? HEIGHT_D : WIDTH_D;
	assign h_d  = rot_q[0] ? WIDTH_D : HEIGHT_D;
	assign ox_e = DIM_W'(ox_q);
	assign oy_e = DIM_W'(oy_q);

	always_comb begin
		map_x  = ox_e;
		map_y  = oy_e;
		map_ok = 1'b1;
		case (rot_q)
			ROT_90: begin
				map_ok = oy_e < h_d;
				map_x  = h_d - DIM_W'(1) - oy_e;
				map_y  = ox_e;
			end
			ROT_180: begin
				map_ok = (ox_e < w_d) && (oy_e < h_d);
				map_x  = w_d - DIM_W'(1) - ox_e;
				map_y  = h_d - DIM_W'(1) - oy_e;
			end
			ROT_270: begin
				map_ok = ox_e < w_d;
				map_x  = oy_e;
				map_y  = w_d - DIM_W'(1) - ox_e;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.map_en) begin
			x_q  <= map_x[COORD_W-1:0];
			y_q  <= map_y[COORD_W-1:0];
			ok_q <= map_ok && (map_x < w_d) && (map_y < h_d) &&
				(colour_q == COL_BLACK || colour_q == COL_WHITE || colour_q == COL_RED);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_q <= PROD_W'(y_q) * PROD_W'(w_d);
		end
	end

	assign sum       = SUM_W'(x_q) + SUM_W'(prod_q);
	assign draw_byte = sum[SUM_W-1:3];
	assign read_byte = BADDR_W'(idx_q);

	always_ff @(posedge clk) begin
		if (ctl.addr_en) begin
			if (cmd_q == CMD_DRAW) begin
				addr_q <= draw_byte[AW-1:0];
				hit_q  <= ok_q && (draw_byte < PB_D);
			end else begin
				addr_q <= read_byte[AW-1:0];
				hit_q  <= read_byte < PB_D;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en && hit_q) begin
			rd_black_q <= black_mem[addr_q];
			rd_red_q   <= red_mem[addr_q];
		end
	end

	// A set bit in one plane is cleared in the other, except for white.
	assign mask      = MASK_MSB >> x_q[2:0];
	assign set_black = (colour_q == COL_WHITE) || (colour_q == COL_BLACK && swap_q) ||
		(colour_q == COL_RED && !swap_q);
	assign set_red   = (colour_q == COL_WHITE) || (colour_q == COL_BLACK && !swap_q) ||
		(colour_q == COL_RED && swap_q);
	assign new_black = set_black ? (rd_black_q | mask) : (rd_black_q & ~mask);
	assign new_red   = set_red ? (rd_red_q | mask) : (rd_red_q & ~mask);

	always_comb begin
		fill_black = BYTE_ZEROS;
		fill_red   = BYTE_ONES;
		if (ctl.fill_zero) begin
			fill_red = BYTE_ZEROS;
		end else if (colour_q == COL_WHITE) begin
			fill_black = BYTE_ONES;
		end else if (colour_q == COL_RED) begin
			fill_black = BYTE_ONES;
			fill_red   = BYTE_ZEROS;
		end
	end

	assign draw_commit = ctl.commit && (cmd_q == CMD_DRAW) && hit_q;
	assign we          = ctl.fill_en || draw_commit;
	assign waddr       = ctl.fill_en ? fill_cnt_q : addr_q;
	assign wdata_black = ctl.fill_en ? fill_black : new_black;
	assign wdata_red   = ctl.fill_en ? fill_red : new_red;

	always_ff @(posedge clk) begin
		if (we) begin
			black_mem[waddr] <= wdata_black;
			red_mem[waddr]   <= wdata_red;
		end
	end

	// The sweep counter wraps to zero on its last entry, so it rests at zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_cnt_q <= '0;
		end else if (ctl.fill_en) begin
			fill_cnt_q <= (fill_cnt_q == LAST_D) ? '0 : fill_cnt_q + AW'(1);
		end
	end

	assign stat.fill_last = fill_cnt_q == LAST_D;

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			res_accepted <= 1'b0;
			res_black    <= BYTE_ZEROS;
			res_red      <= BYTE_ZEROS;
			case (cmd_q)
				CMD_DRAW:  res_accepted <= hit_q;
				CMD_CLEAR: res_accepted <= 1'b1;
				CMD_READ: begin
					res_accepted <= hit_q;
					if (hit_q) begin
						res_black <= rd_black_q;
						res_red   <= rd_red_q;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// File: src/rtpp_ctrl.sv
module rtpp_ctrl import rtpp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [CMD_W-1:0] in_cmd,
	output logic             out_valid,
	input  logic             out_ready,
	output rtpp_cmd_t        ctl,
	input  rtpp_stat_t       stat
);

	`include "rotated_two_plane_pixel_plotter_assert.svh"

	localparam logic [2:0] S_INIT = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_MAP  = 3'd2;
	localparam logic [2:0] S_MUL  = 3'd3;
	localparam logic [2:0] S_ADDR = 3'd4;
	localparam logic [2:0] S_READ = 3'd5;
	localparam logic [2:0] S_FILL = 3'd6;
	localparam logic [2:0] S_DONE = 3'd7;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;
	logic       out_free;
	logic       in_xfer;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = state_q == S_IDLE;
	assign in_xfer  = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			S_INIT: begin
				ctl.fill_en   = 1'b1;
				ctl.fill_zero = 1'b1;
				if (stat.fill_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					ctl.load = 1'b1;
					case (in_cmd)
						CMD_DRAW:  state_d = S_MAP;
						CMD_CLEAR: state_d = S_FILL;
						CMD_READ:  state_d = S_ADDR;
						default:   state_d = S_DONE;
					endcase
				end
			end
			S_MAP: begin
				ctl.map_en = 1'b1;
				state_d    = S_MUL;
			end
			S_MUL: begin
				ctl.mul_en = 1'b1;
				state_d    = S_ADDR;
			end
			S_ADDR: begin
				ctl.addr_en = 1'b1;
				state_d     = S_READ;
			end
			S_READ: begin
				ctl.rd_en = 1'b1;
				state_d   = S_DONE;
			end
			S_FILL: begin
				ctl.fill_en = 1'b1;
				if (stat.fill_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				// The pixel write and the result load happen together, once.
				if (out_free) begin
					ctl.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`RTPP_ASSERT_NOW(a_no_overwrite, ctl.commit, !out_valid_q || out_ready, "result overwritten")
	`RTPP_ASSERT_NEXT(a_leave_idle, in_xfer, state_q != S_IDLE, "accepted item not started")
	`RTPP_ASSERT_NEXT(a_fill_ends, state_q == S_FILL && stat.fill_last, state_q == S_DONE,
		"clear sweep did not finish")
	`RTPP_ASSERT_NOW(a_fell_taken, $fell(out_valid_q), $past(out_ready), "result dropped")

endmodule

// File: src/rotated_two_plane_pixel_plotter.sv
// Channel   Dir  Contents
// pix_in    in   cmd, pixel_x, pixel_y, colour, byte_index; valid/ready
// res_out   out  accepted, black_byte, red_byte; valid/ready
// wr_*      in   configuration write: wr_en, wr_index, wr_data
//
// One item is worked on at a time; the next is taken once its result sits in the
// output register. Draw steps through map, multiply, address, read and write back;
// read steps through address and read; an undefined command goes straight to the
// final step; clear runs the sweep that writes one byte of each plane per cycle.
// After reset the same sweep zeroes all PLANE_BYTES bytes of both planes
// (4736 by default) before the first item is taken.
// A stalled result holds the block in its final step until the transfer.
module rotated_two_plane_pixel_plotter import rtpp_pkg::*; #(
	parameter int PANEL_WIDTH  = 128,
	parameter int PANEL_HEIGHT = 296
) (
	input  logic                 clk,
	input  logic                 arst_n,
	rtpp_in_if.sink              pix_in,
	rtpp_out_if.source           res_out,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_DW-1:0]    wr_data
);

	rtpp_cmd_t  ctl;
	rtpp_stat_t stat;

	rtpp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pix_in.valid),
		.in_ready  (pix_in.ready),
		.in_cmd    (pix_in.cmd),
		.out_valid (res_out.valid),
		.out_ready (res_out.ready),
		.ctl       (ctl),
		.stat      (stat)
	);

	rtpp_datapath #(
		.PANEL_WIDTH  (PANEL_WIDTH),
		.PANEL_HEIGHT (PANEL_HEIGHT)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.stat         (stat),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.in_cmd       (pix_in.cmd),
		.in_x         (pix_in.pixel_x),
		.in_y         (pix_in.pixel_y),
		.in_colour    (pix_in.colour),
		.in_index     (pix_in.byte_index),
		.res_accepted (res_out.accepted),
		.res_black    (res_out.black_byte),
		.res_red      (res_out.red_byte)
	);

endmodule
